// ===== sv/tag_uid_table_defines.svh =====
// Assertion macros for the card record table checker.
// Needs clk and arst_n in the scope of use; no other dependencies.
`ifndef TAG_UID_TABLE_DEFINES_SVH
`define TAG_UID_TABLE_DEFINES_SVH

// same-cycle implication, reset masked
`define TUT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define TUT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tut_pkg.sv =====
// Shared types and constants for the card record table.
// No dependencies; used by the top level, the match unit and the checker.
`timescale 1ns / 1ps

package tut_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int UID_BYTES_DEF = 10;
	localparam int UID_W         = 80;

	// operation codes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_LOOKUP = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;
	localparam logic [2:0] OP_UPDATE = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] uid_high;
		logic [63:0] uid_low;
		logic [3:0]  compare_length;
		logic [7:0]  mode_in;
		logic [7:0]  folder_in;
		logic [7:0]  track_in;
		logic [15:0] user_high_in;
		logic [63:0] user_low_in;
		logic [4:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  hit_index;
		logic [15:0] uid_high_out;
		logic [63:0] uid_low_out;
		logic [7:0]  mode_out;
		logic [7:0]  folder_out;
		logic [7:0]  track_out;
		logic [15:0] user_high_out;
		logic [63:0] user_low_out;
		logic [5:0]  entry_count;
	} rsp_t;

	// one stored record, one RAM word
	typedef struct packed {
		logic [15:0] uid_high;
		logic [63:0] uid_low;
		logic [7:0]  mode;
		logic [7:0]  folder;
		logic [7:0]  track;
		logic [15:0] user_high;
		logic [63:0] user_low;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage

// ===== sv/tag_uid_table.sv =====
// Append, clear, bad ops and bad indexes answer from idle; read and update from S_READ;
// lookup stops at the first hit or the last record (one RAM read per stored record);
// remove captures the victim, then shifts later records down (one record moved per cycle).
// Throughput: one word at a time, next start taken while done shows; no receiver stall.
// Reset (arst_n low) empties the table and returns to idle; record RAM is not cleared.
// Depends on tut_pkg, tut_ram and tut_match.
`timescale 1ns / 1ps

module tag_uid_table #(
	parameter int DEPTH     = tut_pkg::DEPTH_DEF,
	parameter int UID_BYTES = tut_pkg::UID_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tut_pkg::cmd_t cmd,
	output logic          done,
	output tut_pkg::rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // RAM address
	localparam int CW = $clog2(DEPTH + 1);                // count, holds DEPTH
	localparam int XW = (CW > 5) ? CW : 5;                // index compare width

	// Controller states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,  // lookup: compare last read, issue next
		S_READ  = 5'b00100,  // read / update: data back from RAM
		S_RMV   = 5'b01000,  // remove: capture victim record
		S_SHIFT = 5'b10000   // remove: move record i+1 down to i
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q, ptr_d;   // next RAM read address
	logic [AW-1:0] cur_q, cur_d;   // address of record being compared / reported
	logic [AW-1:0] wa_q, wa_d;     // shift write address for pending read
	logic          pend_q, pend_d; // shift read outstanding

	tut_pkg::cmd_t cmd_q;          // word under work
	tut_pkg::rec_t rec_q, rec_d;   // removed record

	tut_pkg::rsp_t rsp_q, rsp_d;
	logic          done_q, done_d;

	// RAM port
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	tut_pkg::rec_t     ram_wdata, rd_rec, upd_rec, cmd_rec;
	logic [tut_pkg::REC_W-1:0] ram_rdata;

	logic idx_ok, m_hit, more;

	tut_ram #(
		.WIDTH(tut_pkg::REC_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_rec = tut_pkg::rec_t'(ram_rdata);

	tut_match #(
		.UID_BYTES(UID_BYTES)
	) u_match (
		.key           ({cmd_q.uid_high, cmd_q.uid_low}),
		.stored        ({rd_rec.uid_high, rd_rec.uid_low}),
		.compare_length(cmd_q.compare_length),
		.hit           (m_hit)
	);

	// new record built from the incoming word (append)
	always_comb begin
		cmd_rec.uid_high  = cmd.uid_high;
		cmd_rec.uid_low   = cmd.uid_low;
		cmd_rec.mode      = cmd.mode_in;
		cmd_rec.folder    = cmd.folder_in;
		cmd_rec.track     = cmd.track_in;
		cmd_rec.user_high = cmd.user_high_in;
		cmd_rec.user_low  = cmd.user_low_in;
	end

	// update keeps the stored UID, takes the rest from the held word
	always_comb begin
		upd_rec           = rd_rec;
		upd_rec.mode      = cmd_q.mode_in;
		upd_rec.folder    = cmd_q.folder_in;
		upd_rec.track     = cmd_q.track_in;
		upd_rec.user_high = cmd_q.user_high_in;
		upd_rec.user_low  = cmd_q.user_low_in;
	end

	function automatic tut_pkg::rsp_t with_rec(tut_pkg::rsp_t r, tut_pkg::rec_t x);
		tut_pkg::rsp_t o;
		o               = r;
		o.uid_high_out  = x.uid_high;
		o.uid_low_out   = x.uid_low;
		o.mode_out      = x.mode;
		o.folder_out    = x.folder;
		o.track_out     = x.track;
		o.user_high_out = x.user_high;
		o.user_low_out  = x.user_low;
		return o;
	endfunction

	assign idx_ok = XW'(cmd.entry_index) < XW'(count_q);
	assign more   = ptr_q < count_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		cur_d     = cur_q;
		wa_d      = wa_q;
		pend_d    = pend_q;
		rec_d     = rec_q;
		done_d    = 1'b0;
		rsp_d     = '0;
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = rd_rec;
		ram_re    = 1'b0;
		ram_raddr = AW'(ptr_q);

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.op)
						tut_pkg::OP_APPEND: begin
							done_d = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								rsp_d.status = tut_pkg::ST_FULL;
							end else begin
								ram_we          = 1'b1;
								ram_waddr       = AW'(count_q);
								ram_wdata       = cmd_rec;
								rsp_d           = with_rec(rsp_d, cmd_rec);
								rsp_d.status    = tut_pkg::ST_OK;
								rsp_d.hit_index = 5'(count_q);
								count_d         = count_q + 1'b1;
							end
						end
						tut_pkg::OP_LOOKUP: begin
							if (count_q == '0) begin
								done_d       = 1'b1;
								rsp_d.status = tut_pkg::ST_MISS;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								cur_d     = '0;
								ptr_d     = CW'(1);
								state_d   = S_SCAN;
							end
						end
						tut_pkg::OP_REMOVE,
						tut_pkg::OP_READ,
						tut_pkg::OP_UPDATE: begin
							if (idx_ok) begin
								ram_re    = 1'b1;
								ram_raddr = AW'(cmd.entry_index);
								cur_d     = AW'(cmd.entry_index);
								ptr_d     = CW'(cmd.entry_index) + 1'b1;
								state_d   = (cmd.op == tut_pkg::OP_REMOVE) ? S_RMV : S_READ;
							end else begin
								done_d          = 1'b1;
								rsp_d.status    = tut_pkg::ST_MISS;
								rsp_d.hit_index = cmd.entry_index;
							end
						end
						tut_pkg::OP_CLEAR: begin
							done_d       = 1'b1;
							rsp_d.status = tut_pkg::ST_OK;
							count_d      = '0;
						end
						default: begin
							done_d       = 1'b1;
							rsp_d.status = tut_pkg::ST_MISS;
						end
					endcase
				end
			end

			S_SCAN: begin
				if (m_hit) begin
					done_d          = 1'b1;
					rsp_d           = with_rec(rsp_d, rd_rec);
					rsp_d.status    = tut_pkg::ST_OK;
					rsp_d.hit_index = 5'(cur_q);
					state_d         = S_IDLE;
				end else if (more) begin
					ram_re = 1'b1;
					cur_d  = AW'(ptr_q);
					ptr_d  = ptr_q + 1'b1;
				end else begin
					done_d       = 1'b1;
					rsp_d.status = tut_pkg::ST_MISS;
					state_d      = S_IDLE;
				end
			end

			S_READ: begin
				done_d          = 1'b1;
				rsp_d.status    = tut_pkg::ST_OK;
				rsp_d.hit_index = 5'(cur_q);
				if (cmd_q.op == tut_pkg::OP_UPDATE) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q;
					ram_wdata = upd_rec;
					rsp_d     = with_rec(rsp_d, upd_rec);
				end else begin
					rsp_d = with_rec(rsp_d, rd_rec);
				end
				state_d = S_IDLE;
			end

			S_RMV: begin
				rec_d   = rd_rec;
				pend_d  = 1'b0;
				state_d = S_SHIFT;
			end

			S_SHIFT: begin
				// write-back of the previous read; never the address read this cycle
				ram_we = pend_q;
				if (more) begin
					ram_re = 1'b1;
					wa_d   = AW'(ptr_q - 1'b1);
					ptr_d  = ptr_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					pend_d          = 1'b0;
					count_d         = count_q - 1'b1;
					done_d          = 1'b1;
					rsp_d           = with_rec(rsp_d, rec_q);
					rsp_d.status    = tut_pkg::ST_OK;
					rsp_d.hit_index = 5'(cur_q);
					state_d         = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		rsp_d.entry_count = 6'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		cur_q <= cur_d;
		wa_q  <= wa_d;
		rec_q <= rec_d;
		rsp_q <= rsp_d;
		if (start && state_q == S_IDLE) begin
			cmd_q <= cmd;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== sv/tut_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tut_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/tut_match.sv =====
// Leading-byte UID compare with clamped length.
// Depends on tut_pkg for the UID width.
`timescale 1ns / 1ps

module tut_match #(
	parameter int UID_BYTES = tut_pkg::UID_BYTES_DEF
) (
	input  logic [tut_pkg::UID_W-1:0] key,
	input  logic [tut_pkg::UID_W-1:0] stored,
	input  logic [3:0]                compare_length,
	output logic                      hit
);

	localparam int NB = tut_pkg::UID_W / 8;
	localparam logic [3:0] UB = 4'(UID_BYTES);

	logic [3:0]    len;
	logic [NB-1:0] byte_ok;

	assign len = (compare_length > UB) ? UB : compare_length;

	// byte 0 sits in the top bits
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			byte_ok[i] = (4'(i) >= len) ||
				(key[tut_pkg::UID_W-1-8*i -: 8] == stored[tut_pkg::UID_W-1-8*i -: 8]);
		end
	end

	assign hit = &byte_ok;

endmodule

// ===== sv/tut_chk.sv =====
// Port-level checker for the card record table, bound to the top level.
// Depends on tut_pkg and tag_uid_table_defines.svh.
`timescale 1ns / 1ps
`include "tag_uid_table_defines.svh"

module tut_chk #(
	parameter int DEPTH = tut_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input tut_pkg::rsp_t rsp
);

	`TUT_ASSERT_NXT(a_accept_progress, start && !busy, busy || done, "accepted word stalled")
	`TUT_ASSERT_NXT(a_done_cause, !start && !busy, !done, "result word with no work")
	`TUT_ASSERT_IMP(a_status_legal, done, rsp.status == tut_pkg::ST_OK || rsp.status == tut_pkg::ST_MISS || rsp.status == tut_pkg::ST_FULL, "bad status code")
	`TUT_ASSERT_IMP(a_full_count, done && rsp.status == tut_pkg::ST_FULL, rsp.entry_count == 6'(DEPTH) && rsp.hit_index == '0, "full with room left")
	`TUT_ASSERT_IMP(a_miss_clean, done && rsp.status == tut_pkg::ST_MISS, rsp.uid_high_out == '0 && rsp.uid_low_out == '0 && rsp.mode_out == '0 && rsp.user_low_out == '0, "miss carries record data")

endmodule

bind tag_uid_table tut_chk #(.DEPTH(DEPTH)) u_chk (.*);
